>>> sv/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// shared constants, codes and types of the bucketed priority stack
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int NUM_LEVELS = 16;
   localparam int CAPACITY   = 256;
   localparam int ELEM_BITS  = 32;

   // widths of the beat fields
   localparam int VALUE_BITS = 32;
   localparam int LEVEL_BITS = 4;
   localparam int COUNT_BITS = 9;

   // internal widths
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int SCAN_BITS  = $clog2(NUM_LEVELS);
   localparam int FRESH_BITS = $clog2(CAPACITY + 1);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_POP_EMPTY  = 2'd2,
      STATUS_LEVEL_HIGH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FREE_RD,
      ST_PUSH_WR,
      ST_POP_RD,
      ST_SCAN,
      ST_ELEM_RD,
      ST_DONE
   } state_type;

   // chain link: valid flag and slot
   typedef struct packed {
      logic                 vld;
      logic [SLOT_BITS-1:0] slot;
   } link_type;

   // node pool access command
   typedef struct packed {
      logic [SLOT_BITS-1:0] link_rd_addr;
      logic [SLOT_BITS-1:0] elem_rd_addr;
      logic [SLOT_BITS-1:0] wr_addr;
      logic                 link_we;
      link_type             link_wr_data;
      logic                 elem_we;
      logic [ELEM_BITS-1:0] elem_wr_data;
   } pool_cmd_type;

endpackage

>>> sv/bps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps channels
// request, response and control register channels with valid/ready
// ----------------------------------------------------------------------------
interface bps_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [bps_pkg::VALUE_BITS-1:0]  element;
   logic [bps_pkg::LEVEL_BITS-1:0]  level;

   modport source (output valid, operation, element, level, input ready);
   modport sink   (input valid, operation, element, level, output ready);
endinterface

interface bps_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bps_pkg::VALUE_BITS-1:0]  top_value;
   logic [bps_pkg::LEVEL_BITS-1:0]  top_level;
   logic [bps_pkg::COUNT_BITS-1:0]  count;
   logic                            is_empty;
   logic [1:0]                      status;

   modport source (output valid, top_value, top_level, count, is_empty, status,
                   input ready);
   modport sink   (input valid, top_value, top_level, count, is_empty, status,
                   output ready);
endinterface

interface bps_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bps_pkg::LEVEL_BITS-1:0]  highest_level;

   modport source (output valid, highest_level, input ready);
   modport sink   (input valid, highest_level, output ready);
endinterface

>>> sv/bps_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pool
// node pool: element and link memories, one write and one registered read each
// ----------------------------------------------------------------------------
module bps_pool (
   input  logic                              clock,
   input  bps_pkg::pool_cmd_type             pool_cmd,
   output bps_pkg::link_type                 link_rd_ff,
   output logic [bps_pkg::ELEM_BITS-1:0]     elem_rd_ff
);

   logic [bps_pkg::ELEM_BITS-1:0] elem_mem [bps_pkg::CAPACITY];
   bps_pkg::link_type             link_mem [bps_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (pool_cmd.elem_we) begin
         elem_mem[pool_cmd.wr_addr] <= pool_cmd.elem_wr_data;
      end
      elem_rd_ff <= elem_mem[pool_cmd.elem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pool_cmd.link_we) begin
         link_mem[pool_cmd.wr_addr] <= pool_cmd.link_wr_data;
      end
      link_rd_ff <= link_mem[pool_cmd.link_rd_addr];
   end

endmodule

>>> sv/bucketed_priority_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_priority_stack_unit
// priority stack with one lifo chain per level over a shared node pool
// ----------------------------------------------------------------------------
// Each request beat pushes an element at a level or pops the newest element
// of the highest non-empty level; each one gives exactly one response beat
// with the new top element, its level, the element count, an empty flag and
// a status (ok, full, pop on empty, level above highest_level). A rejected
// request changes nothing. One request is worked on at a time: req ready is
// high only while the unit is idle. After acceptance a request passes a
// check state, up to two node pool states (free list read, link update),
// the top search, which looks at one level per cycle from the highest
// level down and stops at the first non-empty one, an element read when
// a level is found, and a state that loads the response register once it
// is free; the unit then goes back to idle, where the next request is
// taken. The response sits in an output register, so a new request is
// taken while the last response still waits. The highest_level register
// may be written at any time while idle and resets to 15; lowering it
// never hides stored elements.
// ----------------------------------------------------------------------------
module bucketed_priority_stack_unit (
   input  logic        clock,
   input  logic        reset,
   bps_req_if.sink     req_bus,
   bps_rsp_if.source   rsp_bus,
   bps_csr_if.sink     csr_bus
);

   localparam int SLOT_BITS  = bps_pkg::SLOT_BITS;
   localparam int SCAN_BITS  = bps_pkg::SCAN_BITS;
   localparam int LEVEL_BITS = bps_pkg::LEVEL_BITS;
   localparam int COUNT_BITS = bps_pkg::COUNT_BITS;
   localparam int FRESH_BITS = bps_pkg::FRESH_BITS;
   localparam int ELEM_BITS  = bps_pkg::ELEM_BITS;
   localparam int VALUE_BITS = bps_pkg::VALUE_BITS;

   // sequencer
   bps_pkg::state_type state_ff, state_in;

   // latched request
   bps_pkg::op_type         op_ff;
   logic [ELEM_BITS-1:0]    elem_ff;
   logic [LEVEL_BITS-1:0]   lvl_ff;

   // control register
   logic [LEVEL_BITS-1:0]   max_lvl_ff;

   // chain heads, one per level, with valid bits cleared by reset
   logic [SLOT_BITS-1:0]    head_slot_ff [bps_pkg::NUM_LEVELS];
   logic [bps_pkg::NUM_LEVELS-1:0] head_vld_ff;

   // free list head, never-used slot counter, element count
   bps_pkg::link_type       free_ff;
   logic [FRESH_BITS-1:0]   fresh_ff;
   logic [COUNT_BITS-1:0]   count_ff;

   // result of the last top search
   logic                    top_vld_ff;
   logic [SCAN_BITS-1:0]    top_lvl_ff;
   logic [ELEM_BITS-1:0]    top_value_ff;

   // working registers
   logic [SCAN_BITS-1:0]    scan_ff;
   logic [SLOT_BITS-1:0]    slot_ff;
   bps_pkg::status_type     status_ff;

   // response register
   logic                    rsp_valid_ff;
   logic [VALUE_BITS-1:0]   rsp_value_ff;
   logic [LEVEL_BITS-1:0]   rsp_level_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;
   logic                    rsp_empty_ff;
   bps_pkg::status_type     rsp_status_ff;

   // single read port on the head table
   logic [SCAN_BITS-1:0]    head_idx;
   logic [SLOT_BITS-1:0]    head_rd_slot;
   logic                    head_rd_vld;

   // request checks
   logic                    lvl_high;
   logic                    pool_full;
   logic                    push_ok;
   logic                    pop_ok;

   // node pool
   bps_pkg::pool_cmd_type   pool_cmd;
   bps_pkg::link_type       link_rd;
   logic [ELEM_BITS-1:0]    elem_rd;

   logic                    req_beat;
   logic                    rsp_free;

   assign req_beat = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // level check first, then capacity
   assign lvl_high  = (lvl_ff > max_lvl_ff) || (32'(lvl_ff) >= bps_pkg::NUM_LEVELS);
   assign pool_full = (32'(count_ff) >= bps_pkg::CAPACITY);
   assign push_ok   = !lvl_high && !pool_full;
   assign pop_ok    = top_vld_ff;

   assign head_rd_slot = head_slot_ff[head_idx];
   assign head_rd_vld  = head_vld_ff[head_idx];

   bps_pool u_pool (
      .clock      (clock),
      .pool_cmd   (pool_cmd),
      .link_rd_ff (link_rd),
      .elem_rd_ff (elem_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bps_pkg::ST_IDLE: begin
            if (req_beat) begin
               state_in = bps_pkg::ST_CHECK;
            end
         end
         bps_pkg::ST_CHECK: begin
            if (op_ff == bps_pkg::OP_PUSH) begin
               if (!push_ok) begin
                  state_in = bps_pkg::ST_SCAN;
               end else if (free_ff.vld) begin
                  state_in = bps_pkg::ST_FREE_RD;
               end else begin
                  state_in = bps_pkg::ST_PUSH_WR;
               end
            end else begin
               state_in = pop_ok ? bps_pkg::ST_POP_RD : bps_pkg::ST_SCAN;
            end
         end
         bps_pkg::ST_FREE_RD: state_in = bps_pkg::ST_PUSH_WR;
         bps_pkg::ST_PUSH_WR: state_in = bps_pkg::ST_SCAN;
         bps_pkg::ST_POP_RD:  state_in = bps_pkg::ST_SCAN;
         bps_pkg::ST_SCAN: begin
            if (head_rd_vld) begin
               state_in = bps_pkg::ST_ELEM_RD;
            end else if (scan_ff == '0) begin
               state_in = bps_pkg::ST_DONE;
            end
         end
         bps_pkg::ST_ELEM_RD: state_in = bps_pkg::ST_DONE;
         bps_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = bps_pkg::ST_IDLE;
            end
         end
         default: state_in = bps_pkg::ST_IDLE;
      endcase
   end

   // outputs: head table index and node pool access
   always_comb begin
      head_idx = SCAN_BITS'(lvl_ff);
      pool_cmd = '0;
      case (state_ff)
         bps_pkg::ST_CHECK: begin
            // push: read the next free node; pop: read the top node's link
            if (op_ff == bps_pkg::OP_PUSH) begin
               pool_cmd.link_rd_addr = free_ff.slot;
            end else begin
               head_idx              = top_lvl_ff;
               pool_cmd.link_rd_addr = head_rd_slot;
            end
         end
         bps_pkg::ST_PUSH_WR: begin
            // new node links to the old head of its level
            pool_cmd.wr_addr           = slot_ff;
            pool_cmd.elem_we           = 1'b1;
            pool_cmd.elem_wr_data      = elem_ff;
            pool_cmd.link_we           = 1'b1;
            pool_cmd.link_wr_data.vld  = head_rd_vld;
            pool_cmd.link_wr_data.slot = head_rd_slot;
         end
         bps_pkg::ST_POP_RD: begin
            // popped node goes onto the free list
            head_idx              = top_lvl_ff;
            pool_cmd.wr_addr      = slot_ff;
            pool_cmd.link_we      = 1'b1;
            pool_cmd.link_wr_data = free_ff;
         end
         bps_pkg::ST_SCAN: begin
            head_idx              = scan_ff;
            pool_cmd.elem_rd_addr = head_rd_slot;
         end
         default: begin
            head_idx = SCAN_BITS'(lvl_ff);
         end
      endcase
   end

   assign req_bus.ready = (state_ff == bps_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.top_value = rsp_value_ff;
   assign rsp_bus.top_level = rsp_level_ff;
   assign rsp_bus.count     = rsp_count_ff;
   assign rsp_bus.is_empty  = rsp_empty_ff;
   assign rsp_bus.status    = rsp_status_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bps_pkg::ST_IDLE;
         max_lvl_ff   <= LEVEL_BITS'(15);
         head_vld_ff  <= '0;
         free_ff.vld  <= 1'b0;
         fresh_ff     <= '0;
         count_ff     <= '0;
         top_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid && csr_bus.ready) begin
            max_lvl_ff <= csr_bus.highest_level;
         end
         case (state_ff)
            bps_pkg::ST_CHECK: begin
               // a fresh slot is taken only when the free list is empty
               if (op_ff == bps_pkg::OP_PUSH && push_ok && !free_ff.vld) begin
                  fresh_ff <= fresh_ff + 1'b1;
               end
            end
            bps_pkg::ST_FREE_RD: begin
               free_ff <= link_rd;
            end
            bps_pkg::ST_PUSH_WR: begin
               head_vld_ff[lvl_ff] <= 1'b1;
               count_ff            <= count_ff + 1'b1;
            end
            bps_pkg::ST_POP_RD: begin
               head_vld_ff[top_lvl_ff] <= link_rd.vld;
               free_ff.vld             <= 1'b1;
               free_ff.slot            <= slot_ff;
               count_ff                <= count_ff - 1'b1;
            end
            bps_pkg::ST_SCAN: begin
               if (head_rd_vld) begin
                  top_vld_ff <= 1'b1;
               end else if (scan_ff == '0) begin
                  top_vld_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
         if (state_ff == bps_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         bps_pkg::ST_IDLE: begin
            if (req_beat) begin
               op_ff   <= bps_pkg::op_type'(req_bus.operation);
               elem_ff <= ELEM_BITS'(req_bus.element);
               lvl_ff  <= req_bus.level;
            end
         end
         bps_pkg::ST_CHECK: begin
            scan_ff <= SCAN_BITS'(bps_pkg::NUM_LEVELS - 1);
            if (op_ff == bps_pkg::OP_PUSH) begin
               if (lvl_high) begin
                  status_ff <= bps_pkg::STATUS_LEVEL_HIGH;
               end else if (pool_full) begin
                  status_ff <= bps_pkg::STATUS_FULL;
               end else begin
                  status_ff <= bps_pkg::STATUS_OK;
               end
               slot_ff <= free_ff.vld ? free_ff.slot : fresh_ff[SLOT_BITS-1:0];
            end else begin
               status_ff <= pop_ok ? bps_pkg::STATUS_OK : bps_pkg::STATUS_POP_EMPTY;
               slot_ff   <= head_rd_slot;
            end
         end
         bps_pkg::ST_PUSH_WR: begin
            head_slot_ff[lvl_ff] <= slot_ff;
         end
         bps_pkg::ST_POP_RD: begin
            head_slot_ff[top_lvl_ff] <= link_rd.slot;
         end
         bps_pkg::ST_SCAN: begin
            if (head_rd_vld) begin
               top_lvl_ff <= scan_ff;
            end else if (scan_ff == '0) begin
               top_value_ff <= '0;
            end else begin
               scan_ff <= scan_ff - 1'b1;
            end
         end
         bps_pkg::ST_ELEM_RD: begin
            top_value_ff <= elem_rd;
         end
         bps_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_value_ff  <= VALUE_BITS'(top_value_ff);
               rsp_level_ff  <= top_vld_ff ? LEVEL_BITS'(top_lvl_ff) : '0;
               rsp_count_ff  <= count_ff;
               rsp_empty_ff  <= (count_ff == '0);
               rsp_status_ff <= status_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> sv/bps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_checker
// port level checks of the bucketed priority stack response beats
// ----------------------------------------------------------------------------
module bps_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [bps_pkg::VALUE_BITS-1:0]   rsp_top_value,
   input  logic [bps_pkg::LEVEL_BITS-1:0]   rsp_top_level,
   input  logic [bps_pkg::COUNT_BITS-1:0]   rsp_count,
   input  logic                             rsp_is_empty,
   input  logic [1:0]                       rsp_status
);

   // stalled response beat holds its top value, count and status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_count) && $stable(rsp_status))
      else $error("response beat changed while stalled");

   // empty flag follows the count, and an empty stack shows no top
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0))
         && (!rsp_is_empty || (rsp_top_value == '0 && rsp_top_level == '0)))
      else $error("empty flag, count and top disagree");

   // a pop on empty leaves the stack empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bps_pkg::STATUS_POP_EMPTY |-> rsp_is_empty)
      else $error("pop on empty reported with elements stored");

   // count stays within the pool
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_count) <= bps_pkg::CAPACITY)
      else $error("count above capacity");

endmodule

bind bucketed_priority_stack_unit bps_checker u_bps_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_top_value (rsp_bus.top_value),
   .rsp_top_level (rsp_bus.top_level),
   .rsp_count     (rsp_bus.count),
   .rsp_is_empty  (rsp_bus.is_empty),
   .rsp_status    (rsp_bus.status)
);
